/* src/jceg_pkg.sv */
`default_nettype none

package jceg_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_BUTTON_COUNT = 3'd0;
  localparam logic [2:0] CFG_AXIS_COUNT   = 3'd1;
  localparam logic [2:0] CFG_POV_PRESENT  = 3'd2;
  localparam logic [2:0] CFG_AXIS_MIN     = 3'd3;
  localparam logic [2:0] CFG_AXIS_MAX     = 3'd4;

  // event source kinds
  localparam logic [1:0] KIND_BUTTON   = 2'd0;
  localparam logic [1:0] KIND_HAT      = 2'd1;
  localparam logic [1:0] KIND_AXIS_POS = 2'd2;
  localparam logic [1:0] KIND_AXIS_NEG = 2'd3;

  // axis classes
  localparam logic [1:0] CLS_LOW  = 2'd0;
  localparam logic [1:0] CLS_MID  = 2'd1;
  localparam logic [1:0] CLS_HIGH = 2'd2;

  localparam int AXIS_PORTS = 6;
  localparam int HAT_DIRS   = 4;

  localparam logic [15:0] HAT_CENTER = 16'd65535;
  localparam logic [15:0] HAT_FULL   = 16'd36000;
  localparam logic [15:0] HAT_HALF   = 16'd18000;
  localparam logic [15:0] HAT_REACH  = 16'd6750;
  localparam int          HAT_STEP   = 9000;
  localparam logic [15:0] AXIS_REST  = 16'd32767;

  // x / 10 == (x * 52429) >> 19, exact for x below 81920
  localparam logic [15:0] TENTH_MUL   = 16'd52429;
  localparam int          TENTH_SHIFT = 19;

  typedef logic [AXIS_PORTS-1:0][15:0] axis_vec_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic eval;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic usable;
    logic cur_event;
    logic rem_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/jceg_ctrl.sv */
`default_nettype none

module jceg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire jceg_pkg::sts_t  sts,
  output jceg_pkg::cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.read    = (state == S_READ);
    cmd.eval    = (state == S_EVAL);
    cmd.emit    = (state == S_SCAN) && sts.cur_event && sts.out_free;
    cmd.step    = (state == S_SCAN) && !sts.rem_zero && (!sts.cur_event || sts.out_free);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        // drop failed polls and unknown devices right here
        if (accept && sts.usable) state_next = S_READ;
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: state_next = S_SCAN;
      S_SCAN: begin
        if (sts.rem_zero) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* src/jceg_dp.sv */
`default_nettype none

module jceg_dp #(
  parameter int MAX_DEVICES = 16,
  parameter int MAX_BUTTONS = 32,
  parameter int MAX_AXES    = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire jceg_pkg::cmd_t        cmd,
  output jceg_pkg::sts_t             sts,
  input  wire logic [3:0]            device,
  input  wire logic                  poll_ok,
  input  wire logic [31:0]           buttons,
  input  wire logic [15:0]           pov,
  input  wire jceg_pkg::axis_vec_t   axes,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [3:0]                 event_device,
  output logic                       pressed,
  output logic [1:0]                 source_kind,
  output logic [4:0]                 source_index,
  output logic                       last
);

  localparam int DW        = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int HAT_LSB   = MAX_BUTTONS;
  localparam int AXIS_LSB  = MAX_BUTTONS + 16;
  localparam int ROW_W     = MAX_BUTTONS + 16 + 16 * MAX_AXES;
  localparam int HAT_BASE  = MAX_BUTTONS;
  localparam int AXIS_BASE = MAX_BUTTONS + jceg_pkg::HAT_DIRS;
  localparam int NUM_SLOTS = AXIS_BASE + 2 * MAX_AXES;
  localparam int SW        = $clog2(NUM_SLOTS);

  localparam logic [ROW_W-1:0] RESET_ROW =
    {{MAX_AXES{jceg_pkg::AXIS_REST}}, jceg_pkg::HAT_CENTER, {MAX_BUTTONS{1'b0}}};

  // configuration
  logic [5:0]  button_count;
  logic [2:0]  axis_count;
  logic        pov_present;
  logic [15:0] axis_min;
  logic [15:0] axis_max;

  // threshold pipeline: mid and diff registered from the configuration, then tol
  logic [15:0] hi_eff;
  logic [16:0] range_sum;
  logic [15:0] mid;
  logic [15:0] diff;
  logic [31:0] prod;
  logic [15:0] tol;
  logic [15:0] lo_th;
  logic [15:0] hi_th;

  // captured poll
  logic [3:0]          device_r;
  logic [31:0]         buttons_r;
  logic [15:0]         pov_r;
  jceg_pkg::axis_vec_t axes_r;

  // per-device previous poll
  logic [ROW_W-1:0]       mem [MAX_DEVICES];
  logic [MAX_DEVICES-1:0] row_valid;
  logic [ROW_W-1:0]       rdata;
  logic                   rvalid;
  logic [ROW_W-1:0]       old_row;
  logic [ROW_W-1:0]       new_row;
  logic [DW-1:0]          addr;

  // event slots
  logic [NUM_SLOTS-1:0] ev_mask;
  logic [NUM_SLOTS-1:0] ev_press;
  logic [NUM_SLOTS-1:0] ev_neg;
  logic [NUM_SLOTS-1:0] rem;
  logic [NUM_SLOTS-1:0] press_sh;
  logic [NUM_SLOTS-1:0] neg_sh;
  logic [SW-1:0]        slot;
  logic [1:0]           kind_d;
  logic [4:0]           idx_d;

  function automatic logic hat_down(input logic [15:0] angle, input logic [15:0] target);
    logic [15:0] gap;
    gap = (angle >= target) ? angle - target : target - angle;
    if (gap > jceg_pkg::HAT_HALF) gap = jceg_pkg::HAT_FULL - gap;
    return (angle < jceg_pkg::HAT_FULL) && (gap <= jceg_pkg::HAT_REACH);
  endfunction

  function automatic logic [1:0] axis_class(input logic [15:0] v, input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [1:0] c;
    c = jceg_pkg::CLS_MID;
    if (v < lo) c = jceg_pkg::CLS_LOW;
    else if (v > hi) c = jceg_pkg::CLS_HIGH;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      button_count <= 6'd32;
      axis_count   <= 3'd6;
      pov_present  <= 1'b1;
      axis_min     <= 16'd0;
      axis_max     <= 16'd65535;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jceg_pkg::CFG_BUTTON_COUNT: button_count <= cfg_data[5:0];
        jceg_pkg::CFG_AXIS_COUNT:   axis_count   <= cfg_data[2:0];
        jceg_pkg::CFG_POV_PRESENT:  pov_present  <= cfg_data[0];
        jceg_pkg::CFG_AXIS_MIN:     axis_min     <= cfg_data;
        jceg_pkg::CFG_AXIS_MAX:     axis_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // inverted range collapses to a single point
  assign hi_eff    = (axis_max < axis_min) ? axis_min : axis_max;
  assign range_sum = {1'b0, axis_min} + {1'b0, hi_eff};
  assign prod      = 32'(diff) * 32'(jceg_pkg::TENTH_MUL);
  assign lo_th     = mid - tol;
  assign hi_th     = mid + tol;

  always_ff @(posedge clk) begin
    mid  <= range_sum[16:1];
    diff <= hi_eff - range_sum[16:1];
    tol  <= 16'(prod >> jceg_pkg::TENTH_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      device_r  <= device;
      buttons_r <= buttons;
      pov_r     <= pov;
      axes_r    <= axes;
    end
  end

  assign addr    = device_r[DW-1:0];
  assign old_row = rvalid ? rdata : RESET_ROW;
  assign new_row = {axes_r[MAX_AXES-1:0], pov_r, buttons_r[MAX_BUTTONS-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata <= mem[addr];
    end
    if (cmd.eval) begin
      mem[addr] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rvalid    <= 1'b0;
    end else begin
      if (cmd.read) rvalid <= row_valid[addr];
      if (cmd.eval) row_valid[addr] <= 1'b1;
    end
  end

  always_comb begin
    logic od;
    logic nd;
    logic [1:0] c0;
    logic [1:0] c1;
    logic chg;
    ev_mask  = '0;
    ev_press = '0;
    ev_neg   = '0;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      ev_mask[i]  = (i < int'(button_count)) && (old_row[i] != buttons_r[i]);
      ev_press[i] = buttons_r[i];
    end
    for (int d = 0; d < jceg_pkg::HAT_DIRS; d++) begin
      od = hat_down(old_row[HAT_LSB +: 16], 16'(d * jceg_pkg::HAT_STEP));
      nd = hat_down(pov_r, 16'(d * jceg_pkg::HAT_STEP));
      ev_mask[HAT_BASE + d]  = pov_present && (od != nd);
      ev_press[HAT_BASE + d] = nd;
    end
    // two slots per axis: release of the old class, then press of the new
    for (int i = 0; i < MAX_AXES; i++) begin
      c0  = axis_class(old_row[AXIS_LSB + 16 * i +: 16], lo_th, hi_th);
      c1  = axis_class(axes_r[i], lo_th, hi_th);
      chg = (i < int'(axis_count)) && (c0 != c1);
      ev_mask[AXIS_BASE + 2 * i]      = chg && (c0 != jceg_pkg::CLS_MID);
      ev_press[AXIS_BASE + 2 * i]     = 1'b0;
      ev_neg[AXIS_BASE + 2 * i]       = (c0 == jceg_pkg::CLS_LOW);
      ev_mask[AXIS_BASE + 2 * i + 1]  = chg && (c1 != jceg_pkg::CLS_MID);
      ev_press[AXIS_BASE + 2 * i + 1] = 1'b1;
      ev_neg[AXIS_BASE + 2 * i + 1]   = (c1 == jceg_pkg::CLS_LOW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (cmd.eval) begin
      rem <= ev_mask;
    end else if (cmd.step) begin
      rem <= rem >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      press_sh <= ev_press;
      neg_sh   <= ev_neg;
      slot     <= '0;
    end else if (cmd.step) begin
      press_sh <= press_sh >> 1;
      neg_sh   <= neg_sh >> 1;
      slot     <= slot + 1'b1;
    end
  end

  always_comb begin
    if (int'(slot) < HAT_BASE) begin
      kind_d = jceg_pkg::KIND_BUTTON;
      idx_d  = 5'(slot);
    end else if (int'(slot) < AXIS_BASE) begin
      kind_d = jceg_pkg::KIND_HAT;
      idx_d  = 5'(int'(slot) - HAT_BASE);
    end else begin
      kind_d = neg_sh[0] ? jceg_pkg::KIND_AXIS_NEG : jceg_pkg::KIND_AXIS_POS;
      idx_d  = 5'((int'(slot) - AXIS_BASE) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      event_device <= device_r;
      pressed      <= press_sh[0];
      source_kind  <= kind_d;
      source_index <= idx_d;
      last         <= ((rem >> 1) == '0);
    end
  end

  assign sts.usable    = poll_ok && (int'(device) < MAX_DEVICES);
  assign sts.cur_event = rem[0];
  assign sts.rem_zero  = (rem == '0);
  assign sts.out_free  = !out_valid || out_ready;

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> rem[0] && (!out_valid || out_ready))
    else $error("event loaded without a pending slot or a free output register");

  a_eval_device: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> int'(device_r) < MAX_DEVICES)
    else $error("state row written for a device out of range");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && ((rem >> 1) == '0)) |=> (rem == '0))
    else $error("events remain after the final event of a poll");

endmodule

`default_nettype wire

/* src/joystick_change_event_generator.sv */
`default_nettype none

// Channel  Handshake                Payload
// in       in_valid / in_ready      device, poll_ok, buttons, pov, axis_x..axis_v
// out      out_valid / out_ready    event_device, pressed, source_kind, source_index, last
// cfg      cfg_we (no wait)         cfg_index, cfg_data
//
// A poll is taken in IDLE; the per-device row is read, compared, written back,
// and the event slots (buttons, four hat directions, two per axis) are then
// scanned one slot per cycle, holding on an event slot while the output
// register is held by out_ready low; the scan ends after the last event slot.
// A failed poll or unknown device is taken and dropped in IDLE.
// rst clears the per-device valid bits, so every device reads as released,
// centered and at rest; no clearing pass is needed.
module joystick_change_event_generator #(
  parameter int MAX_DEVICES = 16,
  parameter int MAX_BUTTONS = 32,
  parameter int MAX_AXES    = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  device,
  input  wire logic        poll_ok,
  input  wire logic [31:0] buttons,
  input  wire logic [15:0] pov,
  input  wire logic [15:0] axis_x,
  input  wire logic [15:0] axis_y,
  input  wire logic [15:0] axis_z,
  input  wire logic [15:0] axis_r,
  input  wire logic [15:0] axis_u,
  input  wire logic [15:0] axis_v,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       event_device,
  output logic             pressed,
  output logic [1:0]       source_kind,
  output logic [4:0]       source_index,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  jceg_pkg::cmd_t      cmd;
  jceg_pkg::sts_t      sts;
  jceg_pkg::axis_vec_t axes;

  assign axes = {axis_v, axis_u, axis_r, axis_z, axis_y, axis_x};

  jceg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jceg_dp #(
    .MAX_DEVICES (MAX_DEVICES),
    .MAX_BUTTONS (MAX_BUTTONS),
    .MAX_AXES    (MAX_AXES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .device       (device),
    .poll_ok      (poll_ok),
    .buttons      (buttons),
    .pov          (pov),
    .axes         (axes),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_device (event_device),
    .pressed      (pressed),
    .source_kind  (source_kind),
    .source_index (source_index),
    .last         (last)
  );

endmodule

`default_nettype wire

/* dv/joystick_change_event_generator_test.sv */
`timescale 1ns / 1ps

module joystick_change_event_generator_test;

  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [3:0]          device;
    logic                poll_ok;
    logic [31:0]         buttons;
    logic [15:0]         pov;
    jceg_pkg::axis_vec_t axes;
  } poll_t;

  typedef struct packed {
    logic [3:0] dev;
    logic       pressed;
    logic [1:0] kind;
    logic [4:0] src;
    logic       last;
  } jevent_t;

  class joy_event_book;
    localparam int BTN_LIMIT  = 32;
    localparam int AXIS_LIMIT = 6;

    logic [5:0]  btn_count;
    logic [2:0]  ax_count;
    logic        hat_fitted;
    logic [15:0] ax_lo;
    logic [15:0] ax_hi;

    logic [31:0] last_buttons [16];
    logic [15:0] last_hat [16];
    logic [15:0] last_axes [16][6];

    jevent_t due[$];
    int taken, ignored, checked, faults;

    function new();
      btn_count  = 6'd32;
      ax_count   = 3'd6;
      hat_fitted = 1'b1;
      ax_lo      = 16'd0;
      ax_hi      = 16'd65535;
      for (int d = 0; d < 16; d++) begin
        last_buttons[d] = '0;
        last_hat[d]     = jceg_pkg::HAT_CENTER;
        for (int i = 0; i < 6; i++) last_axes[d][i] = jceg_pkg::AXIS_REST;
      end
      taken = 0; ignored = 0; checked = 0; faults = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        jceg_pkg::CFG_BUTTON_COUNT: btn_count  = val[5:0];
        jceg_pkg::CFG_AXIS_COUNT:   ax_count   = val[2:0];
        jceg_pkg::CFG_POV_PRESENT:  hat_fitted = val[0];
        jceg_pkg::CFG_AXIS_MIN:     ax_lo      = val;
        jceg_pkg::CFG_AXIS_MAX:     ax_hi      = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    function bit hat_on(logic [15:0] angle, int dir);
      int gap;
      if (angle >= jceg_pkg::HAT_FULL) return 1'b0;
      gap = int'(angle) - dir * jceg_pkg::HAT_STEP;
      if (gap < 0) gap = -gap;
      if (gap > int'(jceg_pkg::HAT_HALF)) gap = int'(jceg_pkg::HAT_FULL) - gap;
      return gap <= int'(jceg_pkg::HAT_REACH);
    endfunction

    // an inverted range collapses onto axis_min
    function void axis_edges(output int low_edge, output int high_edge);
      int lo, hi, mid, tol;
      lo = ax_lo;
      hi = (ax_hi < ax_lo) ? ax_lo : ax_hi;
      mid = (lo + hi) / 2;
      tol = (hi - mid) * 10 / 100;
      low_edge  = mid - tol;
      high_edge = mid + tol;
    endfunction

    function logic [1:0] axis_band(logic [15:0] v);
      int low_edge, high_edge;
      axis_edges(low_edge, high_edge);
      if (int'(v) < low_edge) return jceg_pkg::CLS_LOW;
      if (int'(v) > high_edge) return jceg_pkg::CLS_HIGH;
      return jceg_pkg::CLS_MID;
    endfunction

    function void add_event(logic [3:0] dev, logic pr, logic [1:0] kind, int idx);
      due.push_back('{dev: dev, pressed: pr, kind: kind, src: 5'(idx), last: 1'b0});
    endfunction

    function void note_poll(poll_t p);
      int n_btn, n_ax, base;
      logic [1:0] was, now;
      logic [3:0] d;
      if (!p.poll_ok) begin
        ignored++;
        return;
      end
      taken++;
      d = p.device;
      base = due.size();
      n_btn = (btn_count > BTN_LIMIT) ? BTN_LIMIT : btn_count;
      for (int i = 0; i < n_btn; i++)
        if (last_buttons[d][i] != p.buttons[i])
          add_event(d, p.buttons[i], jceg_pkg::KIND_BUTTON, i);
      if (hat_fitted)
        for (int i = 0; i < jceg_pkg::HAT_DIRS; i++)
          if (hat_on(last_hat[d], i) != hat_on(p.pov, i))
            add_event(d, hat_on(p.pov, i), jceg_pkg::KIND_HAT, i);
      n_ax = (ax_count > AXIS_LIMIT) ? AXIS_LIMIT : ax_count;
      for (int i = 0; i < n_ax; i++) begin
        was = axis_band(last_axes[d][i]);
        now = axis_band(p.axes[i]);
        if (was != now) begin
          // release the old class before pressing the new one
          if (was == jceg_pkg::CLS_LOW) add_event(d, 1'b0, jceg_pkg::KIND_AXIS_NEG, i);
          else if (was == jceg_pkg::CLS_HIGH) add_event(d, 1'b0, jceg_pkg::KIND_AXIS_POS, i);
          if (now == jceg_pkg::CLS_LOW) add_event(d, 1'b1, jceg_pkg::KIND_AXIS_NEG, i);
          else if (now == jceg_pkg::CLS_HIGH) add_event(d, 1'b1, jceg_pkg::KIND_AXIS_POS, i);
        end
      end
      last_buttons[d] = p.buttons;
      last_hat[d]     = p.pov;
      for (int i = 0; i < 6; i++) last_axes[d][i] = p.axes[i];
      if (due.size() > base) due[due.size() - 1].last = 1'b1;
    endfunction

    function string show(jevent_t e);
      return $sformatf("dev=%0d pressed=%0b kind=%0d src=%0d last=%0b",
                       e.dev, e.pressed, e.kind, e.src, e.last);
    endfunction

    function void complain(string msg);
      faults++;
      if (faults <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void match_event(jevent_t got);
      jevent_t want;
      checked++;
      if (due.size() == 0) begin
        complain({"unexpected event ", show(got)});
        return;
      end
      want = due.pop_front();
      if (got.dev !== want.dev || got.pressed !== want.pressed || got.kind !== want.kind ||
          got.src !== want.src || got.last !== want.last)
        complain({"expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  device;
  logic        poll_ok;
  logic [31:0] buttons;
  logic [15:0] pov;
  logic [15:0] axis_x;
  logic [15:0] axis_y;
  logic [15:0] axis_z;
  logic [15:0] axis_r;
  logic [15:0] axis_u;
  logic [15:0] axis_v;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  event_device;
  logic        pressed;
  logic [1:0]  source_kind;
  logic [4:0]  source_index;
  logic        last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  joy_event_book book;
  int burst_left;
  int setups;
  bit squeeze_req;

  joystick_change_event_generator DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // hold the output side on a shifting pattern; a requested squeeze stalls it outright
  initial begin : drain
    int mode, mode_left, hold_left;
    jevent_t got;
    mode = 0; mode_left = 0; hold_left = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (out_valid && out_ready) begin
        got = '{event_device, pressed, source_kind, source_index, last};
        book.match_event(got);
      end
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(2, 0);
          mode_left = $urandom_range(80, 5);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(3, 0) != 0);
          default: out_ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
      @(posedge clk);
    end
  end

  task automatic offer(input poll_t p);
    in_valid <= 1'b1;
    device   <= p.device;
    poll_ok  <= p.poll_ok;
    buttons  <= p.buttons;
    pov      <= p.pov;
    axis_x   <= p.axes[0];
    axis_y   <= p.axes[1];
    axis_z   <= p.axes[2];
    axis_r   <= p.axes[3];
    axis_u   <= p.axes[4];
    axis_v   <= p.axes[5];
    do @(posedge clk); while (!in_ready);
    book.note_poll(p);
  endtask

  task automatic send(input poll_t p);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 0) == 0 ? $urandom_range(60, 1) : $urandom_range(4, 1))
        @(posedge clk);
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(30, 10) : $urandom_range(8, 1);
    end
    burst_left--;
    offer(p);
  endtask

  // drop valid, wait for every expected event, then let any zero-event poll finish
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    book.set_reg(idx, val);
  endtask

  task automatic apply_setup(input logic [5:0] bc, input logic [2:0] ac, input logic hat,
                             input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] junk;
    settle();
    junk = 16'($urandom);
    // upper bits of the narrow registers are don't-care
    put_reg(jceg_pkg::CFG_BUTTON_COUNT, {junk[15:6], bc});
    put_reg(jceg_pkg::CFG_AXIS_COUNT, {junk[12:0], ac});
    put_reg(jceg_pkg::CFG_POV_PRESENT, {junk[14:0], hat});
    put_reg(jceg_pkg::CFG_AXIS_MIN, lo);
    put_reg(jceg_pkg::CFG_AXIS_MAX, hi);
    cfg_we <= 1'b0;
    setups++;
  endtask

  function automatic poll_t poll_of(logic [3:0] dev, logic ok, logic [31:0] btn,
                                    logic [15:0] angle, jceg_pkg::axis_vec_t ax);
    poll_t p;
    p.device = dev; p.poll_ok = ok; p.buttons = btn; p.pov = angle; p.axes = ax;
    return p;
  endfunction

  function automatic logic [15:0] hat_probe();
    logic [15:0] marks [15];
    marks = '{jceg_pkg::HAT_CENTER, 16'd0, 16'd4500, 16'd6750, 16'd6751, 16'd9000,
              16'd15750, 16'd15751, 16'd18000, 16'd22500, 16'd27000, 16'd29249,
              16'd29250, 16'd35999, 16'd36000};
    case ($urandom_range(3, 0))
      0: return 16'($urandom_range(35999, 0));
      1: return 16'($urandom_range(65534, 36000));
      default: return marks[$urandom_range(14, 0)];
    endcase
  endfunction

  // aim at the class boundaries of the current range
  function automatic logic [15:0] axis_probe();
    int low_edge, high_edge;
    book.axis_edges(low_edge, high_edge);
    case ($urandom_range(9, 0))
      0: return book.ax_lo;
      1: return book.ax_hi;
      2: return 16'(low_edge - 1);
      3: return 16'(low_edge);
      4: return 16'(high_edge);
      5: return 16'(high_edge + 1);
      6: return 16'd0;
      7: return 16'd65535;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    int pick;
    logic [3:0] d;
    pick = $urandom_range(99, 0);
    d = (pick % 2) ? 4'($urandom_range(3, 0)) : 4'($urandom);
    p.device = d;
    p.poll_ok = 1'b1;
    if (pick < 22) begin
      p.buttons = $urandom;
      p.pov = 16'($urandom);
      for (int i = 0; i < 6; i++) p.axes[i] = 16'($urandom);
      if (pick < 8) p.poll_ok = 1'b0;
    end else begin
      p.buttons = book.last_buttons[d];
      repeat ($urandom_range(3, 0)) p.buttons[$urandom_range(31, 0)] ^= 1'b1;
      if ($urandom_range(9, 0) == 0) p.buttons ^= $urandom;
      p.pov = ($urandom_range(2, 0) == 0) ? book.last_hat[d] : hat_probe();
      for (int i = 0; i < 6; i++)
        p.axes[i] = $urandom_range(1, 0) ? book.last_axes[d][i] : axis_probe();
    end
    return p;
  endfunction

  task automatic random_run(input int polls);
    int sent;
    poll_t p;
    sent = 0;
    while (sent < polls) begin
      p = random_poll();
      send(p);
      if (p.poll_ok) sent++;
    end
  endtask

  initial begin
    jceg_pkg::axis_vec_t edges;
    book = new();
    burst_left = 0;
    setups = 0;
    squeeze_req = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    device    <= '0;
    poll_ok   <= 1'b0;
    buttons   <= '0;
    pov       <= '0;
    axis_x    <= '0;
    axis_y    <= '0;
    axis_z    <= '0;
    axis_r    <= '0;
    axis_u    <= '0;
    axis_v    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: full swings, hat boundaries, axis class edges
    edges = {16'd65535, 16'd32767, 16'd36044, 16'd36043, 16'd29491, 16'd29490};
    send(poll_of(4'd0, 1'b1, 32'hFFFF_FFFF, 16'd0, {6{16'hFFFF}}));
    send(poll_of(4'd0, 1'b1, 32'h0000_0000, 16'd22500, {6{16'h0000}}));
    send(poll_of(4'd0, 1'b1, 32'hFFFF_FFFF, 16'd4500, {6{16'hFFFF}}));
    send(poll_of(4'd0, 1'b0, 32'h0000_0000, 16'd22500, {6{16'h0000}}));
    send(poll_of(4'd0, 1'b1, 32'hFFFF_FFFF, 16'd4500, {6{16'hFFFF}}));
    send(poll_of(4'd1, 1'b1, 32'h8000_0001, 16'd6750, edges));
    send(poll_of(4'd1, 1'b1, 32'h8000_0001, 16'd6751, edges));
    send(poll_of(4'd1, 1'b1, 32'h8000_0000, 16'd35999, edges));
    send(poll_of(4'd1, 1'b1, 32'h8000_0000, 16'd29250, edges));
    send(poll_of(4'd1, 1'b1, 32'h0000_0000, 16'd36000, {6{16'd32767}}));
    send(poll_of(4'd1, 1'b1, 32'h0000_0000, 16'd65534, {6{16'd32767}}));
    send(poll_of(4'd15, 1'b1, 32'h5555_AAAA, 16'd18000,
                 {16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535}));

    // nothing scanned: changes are stored silently
    apply_setup(6'd0, 3'd0, 1'b0, 16'd1000, 16'd2000);
    send(poll_of(4'd2, 1'b1, 32'hFFFF_FFFF, 16'd9000, {6{16'hFFFF}}));
    send(poll_of(4'd2, 1'b1, 32'h0000_0000, 16'd27000, {6{16'd1500}}));

    // counts beyond the limits, inverted range
    apply_setup(6'd63, 3'd7, 1'b1, 16'd50000, 16'd10000);
    send(poll_of(4'd2, 1'b1, 32'h0000_FFFF, 16'd27000, {6{16'd50000}}));
    send(poll_of(4'd2, 1'b1, 32'hFFFF_0000, jceg_pkg::HAT_CENTER,
                 {16'd50001, 16'd49999, 16'd50001, 16'd49999, 16'd0, 16'd65535}));

    apply_setup(6'd32, 3'd6, 1'b1, 16'd65535, 16'd65535);
    send(poll_of(4'd3, 1'b1, 32'h0F0F_0F0F, 16'd9000,
                 {16'd0, 16'd65535, 16'd65534, 16'd0, 16'd65535, 16'd65534}));

    apply_setup(6'd1, 3'd1, 1'b1, 16'd0, 16'd1);
    send(poll_of(4'd3, 1'b1, 32'hF0F0_F0F1, 16'd0, {6{16'd1}}));
    send(poll_of(4'd3, 1'b1, 32'hF0F0_F0F0, 16'd0, {6{16'd0}}));

    // random traffic; the first phase starts under a long output stall
    apply_setup(6'd32, 3'd6, 1'b1, 16'd0, 16'd65535);
    squeeze_req = 1'b1;
    burst_left = 40;
    random_run(40);

    apply_setup(6'($urandom_range(40, 0)), 3'($urandom_range(7, 0)), 1'($urandom),
                16'($urandom_range(30000, 0)), 16'($urandom_range(65535, 30000)));
    random_run(40);

    begin : narrow
      logic [15:0] base;
      base = 16'($urandom_range(65000, 0));
      apply_setup(6'd32, 3'd6, 1'b1, base, base + 16'($urandom_range(500, 0)));
    end
    random_run(35);

    apply_setup(6'($urandom), 3'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    random_run(35);

    settle();
    $display("covered %0d polls and %0d failed polls across %0d register setups",
             book.taken, book.ignored, setups);
    $display("checked %0d events, %0d mismatches", book.checked, book.faults);
    if (book.faults == 0 && book.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
src/jceg_pkg.sv
src/jceg_ctrl.sv
src/jceg_dp.sv
src/joystick_change_event_generator.sv
dv/joystick_change_event_generator_test.sv
